@@ rtl/fda_pkg.sv @@
// shared constants, register indexes and control structs for the fall detect alarm timer
// no dependencies; used by every module in rtl
`default_nettype none

package fda_pkg;

    localparam int SAMPLE_BITS_DEF = 14;
    localparam int AXES            = 3;
    localparam int LIMIT_BITS      = 14;
    localparam int TICK_BITS       = 7;
    localparam int DUTY_BITS       = 7;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 14;

    localparam logic [LIMIT_BITS-1:0] DELTA_RESET    = LIMIT_BITS'(3000);
    localparam logic [LIMIT_BITS-1:0] ABSOLUTE_RESET = LIMIT_BITS'(12000);
    localparam logic [TICK_BITS-1:0]  TICKS_RESET    = TICK_BITS'(100);
    localparam logic [DUTY_BITS-1:0]  DUTY_RESET     = DUTY_BITS'(80);
    localparam logic [DUTY_BITS-1:0]  DUTY_MAX       = DUTY_BITS'(100);

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA_LIMIT    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ABSOLUTE_LIMIT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_TICKS    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_DUTY_PCT = CFG_INDEX_BITS'(3);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic            tick;
        logic            check;
        logic [AXES-1:0] trip;
    } fda_ctrl_t;

    typedef struct packed {
        logic alarm_on;
        logic falling;
    } fda_status_t;

endpackage

`default_nettype wire

@@ rtl/fda_axis_lane.sv @@
// one axis lane: delta and absolute limit tests on a single axis
// depends on fda_pkg
`default_nettype none

module fda_axis_lane #(
    parameter int SAMPLE_BITS = fda_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic [SAMPLE_BITS-1:0]          cur,
    input  wire logic [SAMPLE_BITS-1:0]          prev,
    input  wire logic [fda_pkg::LIMIT_BITS-1:0]  delta,
    input  wire logic [fda_pkg::LIMIT_BITS-1:0]  abs_limit,
    output logic                                 trip
);

    localparam int W = ((SAMPLE_BITS > fda_pkg::LIMIT_BITS) ?
                        SAMPLE_BITS : fda_pkg::LIMIT_BITS) + 1;

    logic [W-1:0] cur_w;
    logic [W-1:0] prev_w;
    logic [W-1:0] delta_w;
    logic [W-1:0] abs_w;

    assign cur_w   = W'(cur);
    assign prev_w  = W'(prev);
    assign delta_w = W'(delta);
    assign abs_w   = W'(abs_limit);

    // cur < prev - delta rewritten as cur + delta < prev to stay unsigned
    assign trip = (cur_w > prev_w + delta_w) ||
                  (cur_w + delta_w < prev_w) ||
                  (cur_w > abs_w);

endmodule

`default_nettype wire

@@ rtl/fda_alarm.sv @@
// alarm sequencer and lane merge: holds falling flag, tick counter and alarm state
// depends on fda_pkg
`default_nettype none

module fda_alarm (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fda_pkg::fda_ctrl_t                ctrl,
    input  wire logic [fda_pkg::TICK_BITS-1:0]     alarm_ticks,
    output fda_pkg::fda_status_t                   status
);

    logic                            falling_reg;
    logic                            falling_next;
    logic                            active_reg;
    logic                            active_next;
    logic [fda_pkg::TICK_BITS-1:0]   count_reg;
    logic [fda_pkg::TICK_BITS-1:0]   count_next;

    always_comb
    begin
        falling_next = falling_reg;
        active_next  = active_reg;
        count_next   = count_reg;
        if (ctrl.tick)
        begin
            if (falling_reg)
            begin
                if (count_reg == '0)
                begin
                    active_next = 1'b1;
                    count_next  = fda_pkg::TICK_BITS'(1);
                end
                else if (count_reg == alarm_ticks)
                begin
                    active_next  = 1'b0;
                    count_next   = '0;
                    falling_next = 1'b0;
                end
                else
                begin
                    active_next = 1'b1;
                    count_next  = count_reg + fda_pkg::TICK_BITS'(1);
                end
            end
            // merge of the lane results
            if (ctrl.check && (|ctrl.trip))
            begin
                falling_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            falling_reg <= 1'b0;
            active_reg  <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            falling_reg <= falling_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
        end
    end

    assign status.alarm_on = active_reg;
    assign status.falling  = falling_reg;

    a_active_needs_falling: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> falling_reg)
        else $error("alarm sounding without falling flag");

    a_count_holds_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.tick |=> $stable(count_reg) && $stable(active_reg))
        else $error("alarm state changed without a tick");

    a_count_moves_only_when_falling: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.tick && !falling_reg) |=> $stable(count_reg))
        else $error("alarm counter moved while not falling");

    a_trip_sets_falling: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.tick && ctrl.check && (|ctrl.trip)) |=> falling_reg)
        else $error("lane trip did not set falling");

endmodule

`default_nettype wire

@@ rtl/fall_detect_alarm_timer.sv @@
// fall detect alarm timer top: one result word per accepted word, in the cycle after it
// one word per cycle if not stalled; the result register drains as the next word enters
// three axis lanes test delta and absolute limits side by side, fda_alarm merges them
// reset clears limits to defaults, the alarm, the falling flag and the first-sample mark
// depends on fda_pkg, fda_axis_lane, fda_alarm
`default_nettype none

module fall_detect_alarm_timer #(
    parameter int SAMPLE_BITS = fda_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  kind,
    input  wire logic [SAMPLE_BITS-1:0]                sample_x,
    input  wire logic [SAMPLE_BITS-1:0]                sample_y,
    input  wire logic [SAMPLE_BITS-1:0]                sample_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       alarm_on,
    output logic [fda_pkg::DUTY_BITS-1:0]              alarm_duty,
    output logic                                       fall_flag,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fda_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [fda_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int AXES = fda_pkg::AXES;

    logic [fda_pkg::LIMIT_BITS-1:0] delta_reg;
    logic [fda_pkg::LIMIT_BITS-1:0] abs_reg;
    logic [fda_pkg::TICK_BITS-1:0]  ticks_reg;
    logic [fda_pkg::DUTY_BITS-1:0]  duty_reg;

    logic [SAMPLE_BITS-1:0] cur_reg  [AXES];
    logic [SAMPLE_BITS-1:0] prev_reg [AXES];
    logic [SAMPLE_BITS-1:0] sample_in [AXES];
    logic                   prev_valid_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   accept;
    logic                   take_sample;
    logic                   take_tick;
    logic [AXES-1:0]        trip;
    logic [fda_pkg::DUTY_BITS-1:0] duty_sat;

    fda_pkg::fda_ctrl_t     ctrl;
    fda_pkg::fda_status_t   status;

    assign in_stall    = out_valid_reg && out_stall;
    assign accept      = in_valid && !in_stall;
    assign take_sample = accept && (kind == fda_pkg::KIND_SAMPLE);
    assign take_tick   = accept && (kind == fda_pkg::KIND_TICK);
    assign cfg_ready   = 1'b1;

    assign sample_in[0] = sample_x;
    assign sample_in[1] = sample_y;
    assign sample_in[2] = sample_z;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= fda_pkg::DELTA_RESET;
            abs_reg   <= fda_pkg::ABSOLUTE_RESET;
            ticks_reg <= fda_pkg::TICKS_RESET;
            duty_reg  <= fda_pkg::DUTY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fda_pkg::REG_DELTA_LIMIT:    delta_reg <= cfg_data;
                fda_pkg::REG_ABSOLUTE_LIMIT: abs_reg   <= cfg_data;
                fda_pkg::REG_ALARM_TICKS:    ticks_reg <= cfg_data[fda_pkg::TICK_BITS-1:0];
                fda_pkg::REG_ALARM_DUTY_PCT: duty_reg  <= cfg_data[fda_pkg::DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // axis sample registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (take_sample)
            begin
                cur_reg[i] <= sample_in[i];
                if (!prev_valid_reg)
                begin
                    prev_reg[i] <= sample_in[i];
                end
            end
            else if (take_tick && prev_valid_reg)
            begin
                prev_reg[i] <= cur_reg[i];
            end
        end
    end

    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take_sample)
            begin
                prev_valid_reg <= 1'b1;
            end
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        fda_axis_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .cur       (cur_reg[g]),
            .prev      (prev_reg[g]),
            .delta     (delta_reg),
            .abs_limit (abs_reg),
            .trip      (trip[g])
        );
    end

    assign ctrl.tick  = take_tick;
    assign ctrl.check = prev_valid_reg;
    assign ctrl.trip  = trip;

    fda_alarm u_alarm (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .alarm_ticks (ticks_reg),
        .status      (status)
    );

    assign duty_sat   = (duty_reg > fda_pkg::DUTY_MAX) ? fda_pkg::DUTY_MAX : duty_reg;
    assign out_valid  = out_valid_reg;
    assign alarm_on   = status.alarm_on;
    assign alarm_duty = status.alarm_on ? duty_sat : '0;
    assign fall_flag  = status.falling;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for fall_detect_alarm_timer: a directed table, then random phases under new limits
// every result word is predicted in step with the block and compared field by field
// depends on rtl/fda_pkg.sv and rtl/fall_detect_alarm_timer.sv only
module tb_top;

    localparam int SB          = fda_pkg::SAMPLE_BITS_DEF;
    localparam int AXIS_MAX    = (1 << SB) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 250;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 28;

    localparam logic [fda_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED =
        fda_pkg::CFG_INDEX_BITS'(200);

    typedef logic [SB-1:0] axis_t;

    localparam axis_t                             AXIS_TOP = '1;
    localparam logic [fda_pkg::CFG_DATA_BITS-1:0] DATA_TOP = '1;

    typedef struct packed {
        logic                          alarm_on;
        logic [fda_pkg::DUTY_BITS-1:0] duty;
        logic                          fall;
    } alarm_status_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

    typedef struct packed {
        row_op_t                            op;
        logic                               kind;
        axis_t                              x;
        axis_t                              y;
        axis_t                              z;
        logic [fda_pkg::CFG_INDEX_BITS-1:0] index;
        logic [fda_pkg::CFG_DATA_BITS-1:0]  data;
        logic                               typed;
        logic                               exp_on;
        logic [fda_pkg::DUTY_BITS-1:0]      exp_duty;
        logic                               exp_fall;
    } row_t;

    // index and data are unused on word rows; expected fields only count where typed is set
    // op, kind, x, y, z, index, data, typed, on, duty, fall
    row_t dir_table [DIR_ROWS] = '{
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 1, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_SAMPLE, 0, 0, 0, REG_UNMAPPED, 0, 1, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, AXIS_TOP, AXIS_TOP, AXIS_TOP, REG_UNMAPPED, 0,
          1, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_SAMPLE, AXIS_TOP, 0, 0, REG_UNMAPPED, 0, 1, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 1, 0, 0, 1},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 1, 1, 80, 1},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ALARM_TICKS, 1, 0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ALARM_DUTY_PCT, 127, 0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, REG_UNMAPPED, DATA_TOP, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_SAMPLE, 12000, 12000, 12000, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 1, 1, 100, 1},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 1, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ABSOLUTE_LIMIT, DATA_TOP,
          0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_DELTA_LIMIT, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_SAMPLE, 12000, 12000, 11999, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ALARM_TICKS, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_SAMPLE, 0, AXIS_TOP, 1, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_DELTA_LIMIT, DATA_TOP,
          0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ABSOLUTE_LIMIT, 0, 0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ALARM_DUTY_PCT, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_SAMPLE, 1, 1, 1, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_WORD, fda_pkg::KIND_TICK, 0, 0, 0, REG_UNMAPPED, 0, 0, 0, 0, 0},
        '{ROW_REG, fda_pkg::KIND_SAMPLE, 0, 0, 0, fda_pkg::REG_ALARM_TICKS, 127, 0, 0, 0, 0}
    };

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    logic                               kind      = fda_pkg::KIND_SAMPLE;
    axis_t                              sample_x  = '0;
    axis_t                              sample_y  = '0;
    axis_t                              sample_z  = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               alarm_on;
    logic [fda_pkg::DUTY_BITS-1:0]      alarm_duty;
    logic                               fall_flag;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [fda_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [fda_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // limits and alarm state as the block should hold them
    logic [fda_pkg::LIMIT_BITS-1:0] lim_delta      = fda_pkg::DELTA_RESET;
    logic [fda_pkg::LIMIT_BITS-1:0] lim_absolute   = fda_pkg::ABSOLUTE_RESET;
    logic [fda_pkg::TICK_BITS-1:0]  alarm_len      = fda_pkg::TICKS_RESET;
    logic [fda_pkg::DUTY_BITS-1:0]  duty_pct       = fda_pkg::DUTY_RESET;
    axis_t                 axis_now  [fda_pkg::AXES] = '{default: '0};
    axis_t                 axis_last [fda_pkg::AXES] = '{default: '0};
    axis_t                 sent_axis [fda_pkg::AXES] = '{default: '0};
    logic                           have_first     = 1'b0;
    logic                           fall_pending   = 1'b0;
    logic                           alarm_sounding = 1'b0;
    logic [fda_pkg::TICK_BITS-1:0]  alarm_cnt      = '0;

    alarm_status_t status_due [$];
    int            errors        = 0;
    int            words_checked = 0;
    int            cycles        = 0;

    fall_detect_alarm_timer #(.SAMPLE_BITS(SB)) i_dut (.*);

    always #5 clk = ~clk;

    function automatic alarm_status_t fall_alarm_step(logic k, axis_t x, axis_t y, axis_t z);
        axis_t         incoming [fda_pkg::AXES];
        alarm_status_t s;
        incoming = '{x, y, z};
        if (k == fda_pkg::KIND_SAMPLE)
        begin
            axis_now = incoming;
            if (!have_first)
            begin
                axis_last  = incoming;
                have_first = 1'b1;
            end
        end
        else
        begin
            if (fall_pending)
            begin
                if (alarm_cnt == '0)
                begin
                    alarm_sounding = 1'b1;
                    alarm_cnt      = fda_pkg::TICK_BITS'(1);
                end
                else if (alarm_cnt == alarm_len)
                begin
                    alarm_cnt      = '0;
                    alarm_sounding = 1'b0;
                    fall_pending   = 1'b0;
                end
                else
                begin
                    alarm_cnt      = alarm_cnt + 1'b1;
                    alarm_sounding = 1'b1;
                end
            end
            if (have_first)
            begin
                for (int a = 0; a < fda_pkg::AXES; a++)
                begin
                    if (int'(axis_now[a]) > int'(axis_last[a]) + int'(lim_delta) ||
                        int'(axis_now[a]) < int'(axis_last[a]) - int'(lim_delta) ||
                        int'(axis_now[a]) > int'(lim_absolute))
                        fall_pending = 1'b1;
                end
                axis_last = axis_now;
            end
        end
        s.alarm_on = alarm_sounding;
        s.duty     = !alarm_sounding ? '0 :
                     (duty_pct > fda_pkg::DUTY_MAX ? fda_pkg::DUTY_MAX : duty_pct);
        s.fall     = fall_pending;
        return s;
    endfunction

    function automatic axis_t near_axis(axis_t base, int span);
        int r;
        if ($urandom_range(0, 7) == 0)
            return axis_t'($urandom_range(0, AXIS_MAX));
        r = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (r < 0)
            r = 0;
        if (r > AXIS_MAX)
            r = AXIS_MAX;
        return axis_t'(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [fda_pkg::CFG_DATA_BITS-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return fda_pkg::CFG_DATA_BITS'(AXIS_MAX);
            2, 3: return fda_pkg::CFG_DATA_BITS'($urandom_range(0, 4000));
            default: return fda_pkg::CFG_DATA_BITS'($urandom_range(0, AXIS_MAX));
        endcase
    endfunction

    function automatic logic [fda_pkg::TICK_BITS-1:0] pick_ticks();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return fda_pkg::TICK_BITS'(1);
            2: return fda_pkg::TICK_BITS'(127);
            default: return fda_pkg::TICK_BITS'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [fda_pkg::DUTY_BITS-1:0] pick_duty();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return fda_pkg::DUTY_MAX;
            2: return fda_pkg::DUTY_BITS'(127);
            default: return fda_pkg::DUTY_BITS'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic write_reg(logic [fda_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [fda_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            fda_pkg::REG_DELTA_LIMIT:    lim_delta    = data[fda_pkg::LIMIT_BITS-1:0];
            fda_pkg::REG_ABSOLUTE_LIMIT: lim_absolute = data[fda_pkg::LIMIT_BITS-1:0];
            fda_pkg::REG_ALARM_TICKS:    alarm_len    = data[fda_pkg::TICK_BITS-1:0];
            fda_pkg::REG_ALARM_DUTY_PCT: duty_pct     = data[fda_pkg::DUTY_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(logic k, axis_t x, axis_t y, axis_t z, int gap,
                             logic typed, alarm_status_t typed_status);
        alarm_status_t s;
        @(negedge clk);
        in_valid <= 1'b1;
        kind     <= k;
        sample_x <= x;
        sample_y <= y;
        sample_z <= z;
        do
            @(posedge clk);
        while (in_stall);
        s = fall_alarm_step(k, x, y, z);
        status_due.push_back(typed ? typed_status : s);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic random_word(int gap);
        logic  k;
        axis_t v [fda_pkg::AXES];
        int    span;
        k    = 1'($urandom_range(0, 1));
        span = int'(lim_delta) + 64;
        for (int a = 0; a < fda_pkg::AXES; a++)
        begin
            if (k == fda_pkg::KIND_SAMPLE)
                v[a] = near_axis(sent_axis[a], span);
            else
                v[a] = axis_t'($urandom_range(0, AXIS_MAX));
        end
        if (k == fda_pkg::KIND_SAMPLE)
            sent_axis = v;
        send_word(k, v[0], v[1], v[2], gap, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: short random stalls, free-running stretches, one long hold-off
    initial
    begin
        int stall_left;
        int run_left;
        bit held;
        stall_left = 0;
        run_left   = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && run_left == 0)
            begin
                if (!held && words_checked >= HOLD_AFTER)
                begin
                    held       = 1'b1;
                    stall_left = HOLD_CYCLES;
                    run_left   = 1;
                end
                else if ($urandom_range(0, 5) == 0)
                    run_left = $urandom_range(20, 60);
                else
                begin
                    stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30)
                                                              : $urandom_range(0, 3);
                    run_left   = $urandom_range(1, 4);
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        alarm_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (status_due.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                want = status_due.pop_front();
                if (alarm_on !== want.alarm_on)
                begin
                    $error("alarm_on expected %0d actual %0d", want.alarm_on, alarm_on);
                    errors++;
                end
                if (alarm_duty !== want.duty)
                begin
                    $error("alarm_duty expected %0d actual %0d", want.duty, alarm_duty);
                    errors++;
                end
                if (fall_flag !== want.fall)
                begin
                    $error("fall_flag expected %0d actual %0d", want.fall, fall_flag);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        alarm_status_t typed_st;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            if (dir_table[i].op == ROW_REG)
            begin
                drain();
                write_reg(dir_table[i].index, dir_table[i].data);
            end
            else
            begin
                typed_st = '{dir_table[i].exp_on, dir_table[i].exp_duty, dir_table[i].exp_fall};
                send_word(dir_table[i].kind, dir_table[i].x, dir_table[i].y, dir_table[i].z,
                          pick_gap(), dir_table[i].typed, typed_st);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(fda_pkg::REG_DELTA_LIMIT, pick_limit());
            write_reg(fda_pkg::REG_ABSOLUTE_LIMIT, pick_limit());
            write_reg(fda_pkg::REG_ALARM_TICKS, {7'($urandom_range(0, 127)), pick_ticks()});
            write_reg(fda_pkg::REG_ALARM_DUTY_PCT, {7'($urandom_range(0, 127)), pick_duty()});
            write_reg(fda_pkg::CFG_INDEX_BITS'($urandom_range(
                          int'(fda_pkg::REG_ALARM_DUTY_PCT) + 1, 255)),
                      fda_pkg::CFG_DATA_BITS'($urandom_range(0, AXIS_MAX)));
            // every third phase runs back to back with no sender gaps
            repeat (PHASE_WORDS) random_word((p % 3 == 1) ? 0 : pick_gap());
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
